FILE: rtl/htw_pkg.sv
// Shared types and constants for the Huffman tree-walk decoder.
// No dependencies; every other file in rtl/ uses this package.
package htw_pkg;

    localparam int NODE_COUNT_DEF = 512;
    localparam int IDX_W          = 9;
    localparam int SYM_W          = 8;
    localparam int CNT_W          = 32;
    localparam int CMD_W          = 2;
    localparam int BYTE_W         = 8;
    localparam int TOP_BIT        = 7;
    localparam int POS_W          = 3;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 32;

    // command codes; the fourth code is a no-op
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_START = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROOT  = 1'b0,
        CFG_COUNT = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_STEP,
        ST_FLUSH
    } t_walk_state;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  node_index;
        logic [IDX_W-1:0]  left_child;
        logic [IDX_W-1:0]  right_child;
        logic              is_leaf;
        logic [SYM_W-1:0]  leaf_symbol;
        logic [BYTE_W-1:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last_of_byte;
        logic             stream_done;
    } t_out_item;

    // one node table entry
    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             leaf;
        logic [SYM_W-1:0] sym;
    } t_node;

    typedef struct packed {
        logic [IDX_W-1:0] root;
        logic [CNT_W-1:0] count;
    } t_cfg;

    // walker to result stage
    typedef struct packed {
        logic             emit;
        logic             flush;
        logic [SYM_W-1:0] symbol;
        logic             done;
    } t_res_cmd;

    // result stage to walker
    typedef struct packed {
        logic can_push;
        logic pend_v;
    } t_res_stat;

endpackage

FILE: rtl/htw_in_if.sv
// Input channel of the decoder: valid/ready handshake with one command item.
// Depends on htw_pkg.
interface htw_in_if;
    logic              valid;
    logic              ready;
    htw_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/htw_out_if.sv
// Output channel of the decoder: valid/ready handshake with one symbol item.
// Depends on htw_pkg.
interface htw_out_if;
    logic               valid;
    logic               ready;
    htw_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/huffman_tree_walk_decoder_core.sv
// Huffman tree-walk decoder: node writes, stream starts and data bytes in;
// one transaction per decoded symbol out. A node write, a start or a no-op
// command completes as it is accepted. A data byte is accepted, then the
// current node is read from the node table, then one bit is consumed per
// step (up to eight), each waiting on the registered read of the child node
// just chosen; a byte that ends on a leaf takes one more step to mark its
// final symbol. A byte is held up when the output side holds back symbols.
// The node table has no reset and needs no clearing pass: it must be written
// before it is walked.
// Depends on htw_pkg, htw_in_if, htw_out_if, htw_node_mem, htw_result_stage,
// htw_walker.
module huffman_tree_walk_decoder_core #(
    parameter int NODE_COUNT = htw_pkg::NODE_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [htw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [htw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    htw_in_if.sink                          i_in,
    htw_out_if.source                       o_out
);

    htw_pkg::t_cfg      r_cfg;
    htw_pkg::t_node     wr_node;
    htw_pkg::t_node     rd_node_a;
    htw_pkg::t_node     rd_node_b;
    htw_pkg::t_res_cmd  res_cmd;
    htw_pkg::t_res_stat res_stat;
    logic               wr_en;
    logic [htw_pkg::IDX_W-1:0] rd_idx_a;
    logic [htw_pkg::IDX_W-1:0] rd_idx_b;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                htw_pkg::CFG_ROOT:  r_cfg.root  <= i_cfg_data[htw_pkg::IDX_W-1:0];
                htw_pkg::CFG_COUNT: r_cfg.count <= i_cfg_data[htw_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    htw_node_mem #(
        .NODE_COUNT (NODE_COUNT)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_idx    (i_in.payload.node_index),
        .i_wr_node   (wr_node),
        .i_rd_idx_a  (rd_idx_a),
        .i_rd_idx_b  (rd_idx_b),
        .o_rd_node_a (rd_node_a),
        .o_rd_node_b (rd_node_b)
    );

    htw_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in        (i_in),
        .o_wr_en     (wr_en),
        .o_wr_node   (wr_node),
        .o_rd_idx_a  (rd_idx_a),
        .o_rd_idx_b  (rd_idx_b),
        .i_rd_node_a (rd_node_a),
        .i_rd_node_b (rd_node_b),
        .o_res       (res_cmd),
        .i_res_stat  (res_stat)
    );

    htw_result_stage u_res (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (res_cmd),
        .o_stat  (res_stat),
        .o_out   (o_out)
    );

    // a symbol still waiting for its end-of-byte mark blocks new commands
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !res_stat.pend_v)
        else $error("input ready while a symbol is still pending");

    // exhausting the stream ends the walk, so that symbol closes its byte
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.stream_done) |-> o_out.payload.last_of_byte)
        else $error("stream_done set on a symbol that is not last of its byte");

    // commands other than data bytes complete in their accept cycle
    a_cmd_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.payload.cmd != htw_pkg::CMD_DATA)
        |=> i_in.ready)
        else $error("non-data command held the input channel");

endmodule

FILE: rtl/htw_node_mem.sv
// Node table: one write port, two registered read ports.
// Indices beyond the table read as an all-zero node. Depends on htw_pkg.
module htw_node_mem #(
    parameter int NODE_COUNT = htw_pkg::NODE_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [htw_pkg::IDX_W-1:0]  i_wr_idx,
    input  htw_pkg::t_node             i_wr_node,
    input  logic [htw_pkg::IDX_W-1:0]  i_rd_idx_a,
    input  logic [htw_pkg::IDX_W-1:0]  i_rd_idx_b,
    output htw_pkg::t_node             o_rd_node_a,
    output htw_pkg::t_node             o_rd_node_b
);

    localparam int AW = $clog2(NODE_COUNT);

    htw_pkg::t_node r_mem [NODE_COUNT];
    htw_pkg::t_node r_rd_a;
    htw_pkg::t_node r_rd_b;
    logic           r_ok_a;
    logic           r_ok_b;

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic          wr_ok;
    logic          ok_a;
    logic          ok_b;

    // address range checks
    assign wr_addr   = AW'(i_wr_idx);
    assign rd_addr_a = AW'(i_rd_idx_a);
    assign rd_addr_b = AW'(i_rd_idx_b);
    assign wr_ok     = 32'(i_wr_idx) < 32'(NODE_COUNT);
    assign ok_a      = 32'(i_rd_idx_a) < 32'(NODE_COUNT);
    assign ok_b      = 32'(i_rd_idx_b) < 32'(NODE_COUNT);

    // storage and registered reads
    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_ok) begin
            r_mem[wr_addr] <= i_wr_node;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
        r_ok_a <= ok_a;
        r_ok_b <= ok_b;
    end

    assign o_rd_node_a = r_ok_a ? r_rd_a : '0;
    assign o_rd_node_b = r_ok_b ? r_rd_b : '0;

endmodule

FILE: rtl/htw_result_stage.sv
// Result stage: holds the latest symbol until it is known whether it ends
// its byte, then passes it to the output register. Depends on htw_pkg, htw_out_if.
module htw_result_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  htw_pkg::t_res_cmd  i_cmd,
    output htw_pkg::t_res_stat o_stat,
    htw_out_if.source          o_out
);

    logic                       r_pend_v;
    logic [htw_pkg::SYM_W-1:0]  r_pend_sym;
    logic                       r_pend_done;
    logic                       r_out_v;
    htw_pkg::t_out_item         r_out;

    logic out_free;
    logic pend_to_out;

    assign out_free    = !r_out_v || o_out.ready;
    assign pend_to_out = (i_cmd.emit || i_cmd.flush) && r_pend_v;

    // pending symbol and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
            if (pend_to_out) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
        if (i_cmd.emit) begin
            r_pend_sym  <= i_cmd.symbol;
            r_pend_done <= i_cmd.done;
        end
        if (pend_to_out) begin
            r_out.symbol       <= r_pend_sym;
            r_out.last_of_byte <= i_cmd.flush;
            r_out.stream_done  <= r_pend_done;
        end
    end

    assign o_stat.can_push = !r_pend_v || out_free;
    assign o_stat.pend_v   = r_pend_v;
    assign o_out.valid     = r_out_v;
    assign o_out.payload   = r_out;

endmodule

FILE: rtl/htw_walker.sv
// Tree walker: command decode, bit sequencing and node table addressing.
// Depends on htw_pkg and htw_in_if.
module htw_walker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  htw_pkg::t_cfg              i_cfg,
    htw_in_if.sink                     i_in,
    output logic                       o_wr_en,
    output htw_pkg::t_node             o_wr_node,
    output logic [htw_pkg::IDX_W-1:0]  o_rd_idx_a,
    output logic [htw_pkg::IDX_W-1:0]  o_rd_idx_b,
    input  htw_pkg::t_node             i_rd_node_a,
    input  htw_pkg::t_node             i_rd_node_b,
    output htw_pkg::t_res_cmd          o_res,
    input  htw_pkg::t_res_stat         i_res_stat
);

    htw_pkg::t_walk_state         r_state, n_state;
    logic [htw_pkg::IDX_W-1:0]    r_node, n_node;
    logic [htw_pkg::CNT_W-1:0]    r_bits, n_bits;
    logic [htw_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [htw_pkg::IDX_W-1:0]    r_child, n_child;
    logic [htw_pkg::BYTE_W-1:0]   r_byte, n_byte;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= htw_pkg::ST_IDLE;
            r_node  <= '0;
            r_bits  <= '0;
        end else begin
            r_state <= n_state;
            r_node  <= n_node;
            r_bits  <= n_bits;
        end
        r_pos   <= n_pos;
        r_child <= n_child;
        r_byte  <= n_byte;
    end

    assign o_wr_node.left  = i_in.payload.left_child;
    assign o_wr_node.right = i_in.payload.right_child;
    assign o_wr_node.leaf  = i_in.payload.is_leaf;
    assign o_wr_node.sym   = i_in.payload.leaf_symbol;
    assign o_rd_idx_b      = i_cfg.root;

    // next state, memory addressing and result commands
    always_comb begin
        htw_pkg::t_node                src;
        logic [htw_pkg::IDX_W-1:0]     child;
        logic [htw_pkg::POS_W-1:0]     pos_nx;
        logic [htw_pkg::CNT_W-1:0]     bits_dec;
        logic                          leaf;

        leaf     = i_rd_node_a.leaf;
        src      = leaf ? i_rd_node_b : i_rd_node_a;
        pos_nx   = r_pos - 1'b1;
        bits_dec = r_bits - 1'b1;
        child    = '0;

        n_state    = r_state;
        n_node     = r_node;
        n_bits     = r_bits;
        n_pos      = r_pos;
        n_child    = r_child;
        n_byte     = r_byte;
        o_rd_idx_a = r_node;
        o_wr_en    = 1'b0;
        o_res      = '0;
        i_in.ready = 1'b0;

        unique case (r_state)
            htw_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    case (i_in.payload.cmd)
                        htw_pkg::CMD_WRITE: begin
                            o_wr_en = 1'b1;
                        end
                        htw_pkg::CMD_START: begin
                            n_node = i_cfg.root;
                            n_bits = i_cfg.count;
                        end
                        htw_pkg::CMD_DATA: begin
                            if (r_bits != '0) begin
                                n_byte  = i_in.payload.data_byte;
                                n_pos   = htw_pkg::POS_W'(htw_pkg::TOP_BIT);
                                n_state = htw_pkg::ST_FIRST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // current node entry is in; step on the first bit
            htw_pkg::ST_FIRST: begin
                child      = r_byte[r_pos] ? i_rd_node_a.right : i_rd_node_a.left;
                o_rd_idx_a = child;
                n_child    = child;
                n_state    = htw_pkg::ST_STEP;
            end
            // child entry is in: leaf test, then step on the next bit
            htw_pkg::ST_STEP: begin
                o_rd_idx_a = r_child;
                if (!(leaf && !i_res_stat.can_push)) begin
                    n_bits = bits_dec;
                    if (leaf) begin
                        o_res.emit   = 1'b1;
                        o_res.symbol = i_rd_node_a.sym;
                        o_res.done   = (bits_dec == '0);
                    end
                    if (bits_dec != '0 && r_pos != '0) begin
                        child      = r_byte[pos_nx] ? src.right : src.left;
                        o_rd_idx_a = child;
                        n_child    = child;
                        n_pos      = pos_nx;
                    end else begin
                        n_node = leaf ? i_cfg.root : r_child;
                        if (!leaf && i_res_stat.can_push) begin
                            o_res.flush = 1'b1;
                            n_state     = htw_pkg::ST_IDLE;
                        end else begin
                            n_state = htw_pkg::ST_FLUSH;
                        end
                    end
                end
            end
            // mark the byte's final symbol
            htw_pkg::ST_FLUSH: begin
                if (i_res_stat.can_push) begin
                    o_res.flush = 1'b1;
                    n_state     = htw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = htw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
